// ----- design/eulb_pkg.sv -----
// Package for the epoch undo log buffer: command codes, item layouts,
// stored record layout and sequencer states. No dependencies.
package eulb_pkg;

  localparam int DEFAULT_DEPTH = 32;
  localparam int TAG_W         = 48;
  localparam int EPOCH_W       = 32;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_DRAIN_OLD = 2'd1,
    CMD_DRAIN_ALL = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [TAG_W-1:0]   block_tag;
    logic [EPOCH_W-1:0] block_epoch;
    logic [EPOCH_W-1:0] system_epoch;
    logic [EPOCH_W-1:0] persisted_epoch;
  } req_t;

  typedef struct packed {
    logic               entry_valid;
    logic [TAG_W-1:0]   out_tag;
    logic [EPOCH_W-1:0] out_from_epoch;
    logic [EPOCH_W-1:0] out_till_epoch;
    logic               insert_accepted;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [EPOCH_W-1:0] from_epoch;
    logic [EPOCH_W-1:0] till_epoch;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_e;

endpackage

// ----- design/eulb_req_if.sv -----
// Command channel of the epoch undo log buffer.
// Depends on eulb_pkg for the item layout.
interface eulb_req_if;
  import eulb_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/eulb_rsp_if.sv -----
// Result channel of the epoch undo log buffer.
// Depends on eulb_pkg for the item layout.
interface eulb_rsp_if;
  import eulb_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/eulb_mem.sv -----
// Record store of the epoch undo log buffer: one write port and one read
// port with registered read data. Depends on eulb_pkg for the record layout.
module eulb_mem #(
  parameter int DEPTH = eulb_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  eulb_pkg::rec_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output eulb_pkg::rec_t rdata
);
  import eulb_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued, so the sequencer may stall on it.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- design/eulb_rsp_reg.sv -----
// Output register of the epoch undo log buffer: holds one result item until
// the receiver takes it. Depends on eulb_pkg and eulb_rsp_if.
module eulb_rsp_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  eulb_pkg::rsp_t push_data,
  output logic           free,
  eulb_rsp_if.source     rsp
);
  import eulb_pkg::*;

  logic occupied;
  rsp_t held;

  assign free      = !occupied || rsp.ready;
  assign rsp.valid = occupied;
  assign rsp.data  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (push) begin
      occupied <= 1'b1;
    end else if (rsp.ready) begin
      occupied <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_data;
    end
  end

  `ifndef SYNTH
  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    push |-> free) else $error("result pushed over an untaken item");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    occupied && !rsp.ready |=> occupied && $stable(held))
    else $error("stalled result lost");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !occupied) else $error("result register not empty after reset");
  `endif
endmodule

// ----- design/epoch_undo_log_buffer_unit.sv -----
// Top level of the epoch undo log buffer: sequencer over the record store.
// Depends on eulb_pkg, eulb_req_if, eulb_rsp_if, eulb_mem and eulb_rsp_reg.
//
// Usage: commands arrive on req (valid/ready), results leave on rsp.
// Insert appends a record at the tail and answers with one item whose
// insert_accepted tells whether it was stored (a full buffer rejects it).
// Drain-old emits, oldest first, every record whose from-epoch is at most
// persisted_epoch and compacts the survivors in place; drain-all emits all
// records and empties the buffer. The final item of each command has last
// set; a drain with nothing to emit gives a single empty item with last.
// Timing: an insert or unused code is handled when taken; its item appears
// the next cycle. A drain walks the stored records through the single read
// port, reading each record, then evaluating it and writing it back, then
// closing in a finish step; emits wait while the result register is full.
// A new command is taken only once the previous one is finished.
// Reset empties the buffer at once; the record store needs no clearing.
// When the receiver stalls, the walk pauses on the record it holds and
// resumes when the result register frees; nothing is lost or repeated.
module epoch_undo_log_buffer_unit #(
  parameter int BUFFER_DEPTH = eulb_pkg::DEFAULT_DEPTH
) (
  input logic        clk,
  input logic        rst,
  eulb_req_if.sink   req,
  eulb_rsp_if.source rsp
);
  import eulb_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

  state_e             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      keep, keep_next;
  logic               drain_all, drain_all_next;
  logic [EPOCH_W-1:0] thresh, thresh_next;
  logic               pend_valid, pend_valid_next;
  rec_t               pend, pend_next;

  logic          we, re, free, push, emit, req_fire;
  logic [AW-1:0] waddr;
  rec_t          wdata, rdata;
  rsp_t          push_data;

  eulb_mem #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  eulb_rsp_reg u_rsp (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .free      (free),
    .rsp       (rsp)
  );

  assign req.ready = (state == ST_IDLE) && free;
  assign req_fire  = req.valid && req.ready;
  assign emit      = drain_all || (rdata.from_epoch <= thresh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    keep      <= keep_next;
    drain_all <= drain_all_next;
    thresh    <= thresh_next;
    pend      <= pend_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    keep_next       = keep;
    drain_all_next  = drain_all;
    thresh_next     = thresh;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    we              = 1'b0;
    waddr           = keep[AW-1:0];
    wdata           = rdata;
    re              = 1'b0;
    push            = 1'b0;
    push_data       = '0;

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req.data.cmd)
            CMD_INSERT: begin
              push           = 1'b1;
              push_data.last = 1'b1;
              if (count < DEPTH_C) begin
                we                        = 1'b1;
                waddr                     = count[AW-1:0];
                wdata.tag                 = req.data.block_tag;
                wdata.from_epoch          = req.data.block_epoch;
                wdata.till_epoch          = req.data.system_epoch;
                count_next                = count + 1'b1;
                push_data.insert_accepted = 1'b1;
              end
            end
            CMD_DRAIN_OLD, CMD_DRAIN_ALL: begin
              drain_all_next  = (req.data.cmd == CMD_DRAIN_ALL);
              thresh_next     = req.data.persisted_epoch;
              idx_next        = '0;
              keep_next       = '0;
              pend_valid_next = 1'b0;
              state_next      = (count == '0) ? ST_FINISH : ST_READ;
            end
            default: begin
              push           = 1'b1;
              push_data.last = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        re         = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        // An emitted record waits as pending until we know whether it is the
        // final one, so the previous pending record goes out now without last.
        if (!(emit && pend_valid && !free)) begin
          if (emit) begin
            if (pend_valid) begin
              push                     = 1'b1;
              push_data.entry_valid    = 1'b1;
              push_data.out_tag        = pend.tag;
              push_data.out_from_epoch = pend.from_epoch;
              push_data.out_till_epoch = pend.till_epoch;
            end
            pend_next       = rdata;
            pend_valid_next = 1'b1;
          end else begin
            we        = 1'b1;
            keep_next = keep + 1'b1;
          end
          idx_next   = idx + 1'b1;
          state_next = (idx + 1'b1 == count) ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        if (free) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          if (pend_valid) begin
            push_data.entry_valid    = 1'b1;
            push_data.out_tag        = pend.tag;
            push_data.out_from_epoch = pend.from_epoch;
            push_data.out_till_epoch = pend.till_epoch;
          end
          pend_valid_next = 1'b0;
          count_next      = keep;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("record count beyond buffer depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.data.cmd == CMD_INSERT && count < DEPTH_C
    |=> count == $past(count) + 1'b1) else $error("insert did not store");
  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> keep <= idx && idx < count)
    else $error("compaction overtook the walk");
  a_count_still_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_EVAL) |=> $stable(count))
    else $error("count changed during a drain walk");
  `endif
endmodule
